// ===== hdl/dma_rx_ring_pointer_tracker_defines.svh =====
// Assertion macros used by the checker file of the receive ring tracker.
// Depends on nothing; expects i_clk and i_rst_n in the scope of each use.
`ifndef DMA_RX_RING_POINTER_TRACKER_DEFINES_SVH
`define DMA_RX_RING_POINTER_TRACKER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DMARX_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("dmarx port check failed");

// Next-cycle implication, checked out of reset.
`define DMARX_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("dmarx port check failed");

`endif

// ===== hdl/dmarx_pkg.sv =====
// Shared types and constants of the receive ring pointer tracker.
// Depends on nothing.
`default_nettype none

package dmarx_pkg;

    localparam int DROP_W = 32;
    localparam int LEN_W  = 16;

    typedef enum logic {
        OP_UPDATE = 1'b0,
        OP_READ   = 1'b1
    } t_op;

    typedef struct packed {
        logic two_segs;
        logic overflow;
    } t_step_info;

endpackage

`default_nettype wire

// ===== hdl/dmarx_ptrs.sv =====
// Ring pointer state and the single-pass logic that turns one request into results.
// Depends on dmarx_pkg.
`default_nettype none

module dmarx_ptrs
    import dmarx_pkg::*;
#(
    parameter int RING_SIZE = 256,
    localparam int IW = $clog2(RING_SIZE),
    localparam int RW = $clog2(RING_SIZE + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire t_op               i_op,
    input  wire logic [RW-1:0]     i_rem,
    input  wire logic [LEN_W-1:0]  i_len,
    output logic [IW-1:0]          o_start0,
    output logic [RW-1:0]          o_len0,
    output logic [IW-1:0]          o_start1,
    output logic [RW-1:0]          o_len1,
    output logic [DROP_W-1:0]      o_drops,
    output t_step_info             o_info
);

    localparam int CW = (RW > LEN_W) ? RW : LEN_W;
    localparam logic [RW-1:0] NR = RW'(RING_SIZE);

    logic [IW-1:0]     r_wr_idx, n_wr_idx;
    logic [IW-1:0]     r_rd_idx, n_rd_idx;
    logic [RW-1:0]     r_last_rem, n_last_rem;
    logic [DROP_W-1:0] r_drops, n_drops;

    logic [IW-1:0] space;
    logic [RW:0]   lap_sum;
    logic          rem_gt;
    logic          rem_bad;
    logic [RW:0]   wrap_bytes;
    logic [RW-1:0] bytes;
    logic          fits;

    logic [IW-1:0] used;
    logic [RW-1:0] to_end_len;
    logic [RW-1:0] to_end;
    logic [IW-1:0] chunk1;
    logic [CW-1:0] len1;
    logic [IW-1:0] rd_idx1;
    logic [IW-1:0] used1;
    logic [IW-1:0] chunk2;
    logic          empty_rd;
    logic          two;

    always_comb begin
        // Position update.
        space      = r_rd_idx - r_wr_idx - IW'(1);
        lap_sum    = {1'b0, r_last_rem} + {1'b0, NR};
        rem_gt     = r_last_rem > i_rem;
        rem_bad    = !rem_gt && ({1'b0, i_rem} > lap_sum);
        wrap_bytes = lap_sum - {1'b0, i_rem};
        bytes      = rem_gt ? (r_last_rem - i_rem) : wrap_bytes[RW-1:0];
        fits       = !rem_bad && (bytes <= {1'b0, space});

        // Read request; a second segment only follows a wrap to index zero.
        used       = r_wr_idx - r_rd_idx;
        to_end_len = NR - {1'b0, r_rd_idx};
        to_end     = ({1'b0, used} < to_end_len) ? {1'b0, used} : to_end_len;
        empty_rd   = (i_len == '0) || (used == '0);
        chunk1     = (CW'(to_end) < CW'(i_len)) ? to_end[IW-1:0] : i_len[IW-1:0];
        len1       = CW'(i_len) - CW'(chunk1);
        rd_idx1    = r_rd_idx + chunk1;
        used1      = used - chunk1;
        chunk2     = (CW'(used1) < len1) ? used1 : len1[IW-1:0];
        two        = !empty_rd && (len1 != '0) && (used1 != '0);
    end

    always_comb begin
        n_wr_idx   = r_wr_idx;
        n_rd_idx   = r_rd_idx;
        n_last_rem = r_last_rem;
        n_drops    = r_drops;
        o_start0   = r_rd_idx;
        o_len0     = '0;
        o_start1   = rd_idx1;
        o_len1     = RW'(chunk2);
        o_info     = '0;
        if (i_op == OP_UPDATE) begin
            o_start0 = r_wr_idx;
            if (fits) begin
                o_len0     = bytes;
                n_wr_idx   = r_wr_idx + bytes[IW-1:0];
                n_last_rem = i_rem;
            end else begin
                n_wr_idx        = '0;
                n_rd_idx        = '0;
                n_last_rem      = NR;
                n_drops         = r_drops + DROP_W'(1);
                o_info.overflow = 1'b1;
            end
        end else if (!empty_rd) begin
            o_len0          = RW'(chunk1);
            o_info.two_segs = two;
            n_rd_idx        = two ? (rd_idx1 + chunk2) : rd_idx1;
        end
        o_drops = n_drops;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx   <= '0;
            r_rd_idx   <= '0;
            r_last_rem <= NR;
            r_drops    <= '0;
        end else if (i_step) begin
            r_wr_idx   <= n_wr_idx;
            r_rd_idx   <= n_rd_idx;
            r_last_rem <= n_last_rem;
            r_drops    <= n_drops;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/dma_rx_ring_pointer_tracker.sv =====
// Top level of the receive ring pointer tracker: request register, pointer logic, result buffer.
// Depends on dmarx_pkg and dmarx_ptrs.
//
//   Channel | Dir | tdata (low bit up)                     | tuser     | tlast
//   s_axis  | in  | dma_remaining, max_length              | operation | -
//   m_axis  | out | seg_start, seg_len, drop_count         | overflow  | last
//
// A request is held in the input register until the buffer is free; its one or two results are
// computed in one pass and loaded into a two-entry result buffer.
// Updates and single-segment reads load one result; a split read loads both buffer entries.
// Reset clears the pointers, sets the last remaining count to the ring size and empties
// both registers. A stalled m_axis holds the request register, then s_axis_tready.
`default_nettype none

module dma_rx_ring_pointer_tracker
    import dmarx_pkg::*;
#(
    parameter int RING_SIZE = 256,
    localparam int IW = $clog2(RING_SIZE),
    localparam int RW = $clog2(RING_SIZE + 1),
    localparam int IN_W = ((RW + LEN_W + 7) / 8) * 8,
    localparam int OUT_W = ((IW + RW + DROP_W + 7) / 8) * 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [IN_W-1:0]  s_axis_tdata,   // dma_remaining, max_length
    input  wire logic             s_axis_tuser,   // operation
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,   // seg_start, seg_len, drop_count
    output logic                  m_axis_tuser,   // overflow
    output logic                  m_axis_tlast
);

    logic              r_in_valid;
    t_op               r_in_op;
    logic [RW-1:0]     r_in_rem;
    logic [LEN_W-1:0]  r_in_len;

    logic [1:0]        r_cnt, n_cnt;
    logic [IW-1:0]     r_ob_start [2];
    logic [RW-1:0]     r_ob_len   [2];
    logic              r_ob_ovf   [2];
    logic              r_ob_last  [2];
    logic [DROP_W-1:0] r_ob_drops;

    logic              step;
    logic              pop;
    logic              buf_free;
    logic              in_take;

    logic [IW-1:0]     start0, start1;
    logic [RW-1:0]     len0, len1;
    logic [DROP_W-1:0] drops;
    t_step_info        info;

    dmarx_ptrs #(
        .RING_SIZE (RING_SIZE)
    ) u_ptrs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_op     (r_in_op),
        .i_rem    (r_in_rem),
        .i_len    (r_in_len),
        .o_start0 (start0),
        .o_len0   (len0),
        .o_start1 (start1),
        .o_len1   (len1),
        .o_drops  (drops),
        .o_info   (info)
    );

    always_comb begin
        pop           = (r_cnt != 2'd0) && m_axis_tready;
        buf_free      = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && m_axis_tready);
        step          = r_in_valid && buf_free;
        s_axis_tready = !r_in_valid || step;
        in_take       = s_axis_tvalid && s_axis_tready;
        if (step) begin
            n_cnt = info.two_segs ? 2'd2 : 2'd1;
        end else if (pop) begin
            n_cnt = r_cnt - 2'd1;
        end else begin
            n_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_cnt      <= 2'd0;
        end else begin
            r_in_valid <= in_take || (r_in_valid && !step);
            r_cnt      <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op  <= t_op'(s_axis_tuser);
            r_in_rem <= s_axis_tdata[RW-1:0];
            r_in_len <= s_axis_tdata[RW+LEN_W-1:RW];
        end
        if (step) begin
            r_ob_start[0] <= start0;
            r_ob_len[0]   <= len0;
            r_ob_ovf[0]   <= info.overflow;
            r_ob_last[0]  <= !info.two_segs;
            r_ob_start[1] <= start1;
            r_ob_len[1]   <= len1;
            r_ob_ovf[1]   <= 1'b0;
            r_ob_last[1]  <= 1'b1;
            r_ob_drops    <= drops;
        end else if (pop && (r_cnt == 2'd2)) begin
            r_ob_start[0] <= r_ob_start[1];
            r_ob_len[0]   <= r_ob_len[1];
            r_ob_ovf[0]   <= r_ob_ovf[1];
            r_ob_last[0]  <= r_ob_last[1];
        end
    end

    always_comb begin
        m_axis_tvalid = (r_cnt != 2'd0);
        m_axis_tdata  = OUT_W'({r_ob_drops, r_ob_len[0], r_ob_start[0]});
        m_axis_tuser  = r_ob_ovf[0];
        m_axis_tlast  = r_ob_last[0];
    end

endmodule

`default_nettype wire

// ===== hdl/dmarx_chk.sv =====
// Port-level checker of the receive ring tracker, bound to the top level.
// Depends on dma_rx_ring_pointer_tracker_defines.svh and dma_rx_ring_pointer_tracker.
`default_nettype none
`include "dma_rx_ring_pointer_tracker_defines.svh"

module dmarx_chk #(
    parameter int RING_SIZE = 256,
    localparam int IW = $clog2(RING_SIZE),
    localparam int RW = $clog2(RING_SIZE + 1),
    localparam int OUT_W = ((IW + RW + 32 + 7) / 8) * 8
) (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             m_axis_tvalid,
    input wire logic             m_axis_tready,
    input wire logic [OUT_W-1:0] m_axis_tdata,
    input wire logic             m_axis_tuser,
    input wire logic             m_axis_tlast
);

    logic [RW-1:0]    seg_len;
    logic [OUT_W+1:0] beat;

    assign seg_len = m_axis_tdata[IW+RW-1:IW];
    assign beat    = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

    `DMARX_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(beat))
    `DMARX_ASSERT_IMP(a_ovf_empty, m_axis_tvalid && m_axis_tuser, m_axis_tlast && (seg_len == '0))
    `DMARX_ASSERT_IMP(a_first_seg, m_axis_tvalid && !m_axis_tlast, (seg_len != '0) && !m_axis_tuser)

endmodule

bind dma_rx_ring_pointer_tracker dmarx_chk #(
    .RING_SIZE (RING_SIZE)
) u_dmarx_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== test/dma_rx_ring_pointer_tracker_checker.sv =====
// Result checker for the receive ring pointer tracker: tracks the ring pointers
// from every accepted request and compares each m_axis result against them.
// Depends on dmarx_pkg.
module dma_rx_ring_pointer_tracker_checker
    import dmarx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // dma_remaining, max_length
    input  logic        i_s_axis_tuser,   // operation
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [55:0] i_m_axis_tdata,   // seg_start, seg_len, drop_count
    input  logic        i_m_axis_tuser,   // overflow
    input  logic        i_m_axis_tlast,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count,
    output int          o_overflow_count,
    output int          o_split_count
);

    localparam int unsigned RING = 256;

    typedef struct packed {
        logic [7:0]        seg_start;
        logic [8:0]        seg_len;
        logic              overflow;
        logic [DROP_W-1:0] drop_count;
        logic              last;
    } t_segment;

    t_segment          expected_segments[$];
    logic [7:0]        wr_idx;
    logic [7:0]        rd_idx;
    logic [8:0]        prev_remaining;
    logic [DROP_W-1:0] drop_total;

    task automatic compare_field(input string field, input logic [31:0] expected_value,
                                 input logic [31:0] actual_value);
        if (expected_value !== actual_value) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, expected_value, actual_value);
            o_fail_count++;
        end
    endtask

    task automatic advance_ring(input t_op op, input logic [8:0] remaining,
                                input logic [LEN_W-1:0] want);
        int unsigned arrived;
        int unsigned used;
        int unsigned to_end;
        int unsigned chunk;
        int unsigned left;
        logic [7:0]  free_bytes;
        t_segment    seg;
        t_segment    segs[2];
        int          produced;
        produced = 0;
        seg = '0;
        if (op == OP_UPDATE) begin
            free_bytes = rd_idx - wr_idx - 8'd1;
            seg.seg_start = wr_idx;
            seg.last = 1'b1;
            if (prev_remaining > remaining)
                arrived = prev_remaining - remaining;
            else
                arrived = prev_remaining + RING - remaining;
            prev_remaining = remaining;
            if (arrived <= free_bytes) begin
                wr_idx = wr_idx + arrived[7:0];
                seg.seg_len = arrived[8:0];
            end else begin
                wr_idx = '0;
                rd_idx = '0;
                prev_remaining = 9'(RING);
                drop_total = drop_total + 1'b1;
                seg.overflow = 1'b1;
                o_overflow_count++;
            end
            seg.drop_count = drop_total;
            expected_segments.push_back(seg);
        end else begin
            left = 32'(want);
            seg.drop_count = drop_total;
            while (left > 0 && produced < 2 && wr_idx != rd_idx) begin
                used = 32'(8'(wr_idx - rd_idx));
                to_end = RING - rd_idx;
                chunk = (used < to_end) ? used : to_end;
                if (chunk > left)
                    chunk = left;
                seg.seg_start = rd_idx;
                seg.seg_len = chunk[8:0];
                segs[produced] = seg;
                produced++;
                rd_idx = rd_idx + chunk[7:0];
                left = left - chunk;
            end
            if (produced == 0) begin
                seg.seg_start = rd_idx;
                seg.seg_len = '0;
                seg.last = 1'b1;
                expected_segments.push_back(seg);
            end else begin
                segs[produced-1].last = 1'b1;
                for (int k = 0; k < produced; k++)
                    expected_segments.push_back(segs[k]);
                if (produced == 2)
                    o_split_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_segment got;
        t_segment want_seg;
        if (!i_rst_n) begin
            wr_idx = '0;
            rd_idx = '0;
            prev_remaining = 9'(RING);
            drop_total = '0;
            expected_segments.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.seg_start = i_m_axis_tdata[7:0];
                got.seg_len = i_m_axis_tdata[16:8];
                got.drop_count = i_m_axis_tdata[48:17];
                got.overflow = i_m_axis_tuser;
                got.last = i_m_axis_tlast;
                o_result_count++;
                if (expected_segments.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual start %0d len %0d",
                             $time, got.seg_start, got.seg_len);
                    o_fail_count++;
                end else begin
                    want_seg = expected_segments.pop_front();
                    compare_field("seg_start", 32'(want_seg.seg_start), 32'(got.seg_start));
                    compare_field("seg_len", 32'(want_seg.seg_len), 32'(got.seg_len));
                    compare_field("overflow", 32'(want_seg.overflow), 32'(got.overflow));
                    compare_field("drop_count", want_seg.drop_count, got.drop_count);
                    compare_field("last", 32'(want_seg.last), 32'(got.last));
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                advance_ring(t_op'(i_s_axis_tuser), i_s_axis_tdata[8:0],
                             i_s_axis_tdata[24:9]);
        end
        o_pending = expected_segments.size();
    end

endmodule

// ===== test/dma_rx_ring_pointer_tracker_test.sv =====
// Testbench top for the receive ring pointer tracker: drives update and read
// requests with random idling on both channels and gives the verdict.
// Depends on dmarx_pkg, dma_rx_ring_pointer_tracker and its result checker.
module dma_rx_ring_pointer_tracker_test;
    import dmarx_pkg::*;

    localparam int LIMIT_CYCLES = 100000;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASE_ITEMS = 150;
    localparam int DIRECTED_ITEMS = 22;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // dma_remaining, max_length
    logic        s_axis_tuser = 1'b0; // operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;        // seg_start, seg_len, drop_count
    logic        m_axis_tuser;        // overflow
    logic        m_axis_tlast;

    int         send_idle_pct = 21;
    int         recv_idle_pct = 82;
    int         cycle_count = 0;
    int         hold_count = 0;
    int         request_count = 0;
    bit         hold_armed = 1'b0;
    logic [8:0] dma_position = 9'd256;

    int fail_count;
    int pending;
    int result_count;
    int overflow_count;
    int split_count;

    t_op directed_op[DIRECTED_ITEMS] = '{
        OP_READ, OP_READ, OP_UPDATE, OP_UPDATE, OP_READ, OP_READ, OP_UPDATE, OP_UPDATE,
        OP_UPDATE, OP_UPDATE, OP_READ, OP_READ, OP_UPDATE, OP_READ, OP_READ, OP_UPDATE,
        OP_UPDATE, OP_UPDATE, OP_READ, OP_UPDATE, OP_UPDATE, OP_READ
    };
    int directed_value[DIRECTED_ITEMS] = '{
        0, 65535, 256, 156, 0, 30, 1, 0,
        256, 251, 65535, 1, 200, 10, 65535, 201,
        200, 1, 65535, 0, 511, 65535
    };

    dma_rx_ring_pointer_tracker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    dma_rx_ring_pointer_tracker_checker results_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_axis_tvalid  (s_axis_tvalid),
        .i_s_axis_tready  (s_axis_tready),
        .i_s_axis_tdata   (s_axis_tdata),
        .i_s_axis_tuser   (s_axis_tuser),
        .i_m_axis_tvalid  (m_axis_tvalid),
        .i_m_axis_tready  (m_axis_tready),
        .i_m_axis_tdata   (m_axis_tdata),
        .i_m_axis_tuser   (m_axis_tuser),
        .i_m_axis_tlast   (m_axis_tlast),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_result_count   (result_count),
        .o_overflow_count (overflow_count),
        .o_split_count    (split_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // The long hold-off lets the sender fill the block until s_axis_tready drops.
    always @(negedge i_clk) begin
        if (hold_armed && hold_count < HOLD_CYCLES) begin
            m_axis_tready <= 1'b0;
            hold_count <= hold_count + 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_request(input t_op op, input logic [8:0] remaining,
                                input logic [LEN_W-1:0] want);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {7'd0, want, remaining};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        request_count++;
    endtask

    task automatic send_random_item();
        int             pick;
        int             sel;
        int             step;
        logic [LEN_W-1:0] want;
        logic [8:0]     remaining;
        pick = $urandom_range(99);
        if (pick < 45) begin
            sel = $urandom_range(99);
            if (sel < 10)
                want = '0;
            else if (sel < 30)
                want = LEN_W'($urandom);
            else
                want = LEN_W'($urandom_range(64, 1));
            send_request(OP_READ, 9'($urandom_range(256)), want);
        end else begin
            if (pick < 50) begin
                remaining = 9'($urandom_range(256));
            end else if (pick < 53) begin
                remaining = dma_position;
            end else begin
                step = $urandom_range(60, 1);
                if (dma_position > step)
                    remaining = 9'(dma_position - step);
                else
                    remaining = 9'(dma_position + 256 - step);
            end
            dma_position = remaining;
            send_request(OP_UPDATE, remaining, LEN_W'($urandom));
        end
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < DIRECTED_ITEMS; i++) begin
            if (directed_op[i] == OP_UPDATE)
                send_request(OP_UPDATE, 9'(directed_value[i]), LEN_W'($urandom));
            else
                send_request(OP_READ, 9'($urandom_range(256)), LEN_W'(directed_value[i]));
        end
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 82;
                recv_idle_pct = 21;
            end else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_armed = 1'b1;
            end
            repeat (PHASE_ITEMS)
                send_random_item();
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Sent %0d update and read requests and checked %0d results,", request_count,
                 result_count);
        $display("including %0d ring overflows and %0d reads split at the ring end.",
                 overflow_count, split_count);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
